// ===== rtl/prf_pkg.sv =====
// Package: constants, payload structs and sequencer states for page frame replacement.
`default_nettype none
package prf_pkg;

    localparam int FRAME_COUNT = 5;
    localparam int PAGE_BYTES  = 100;

    localparam int ADDR_W  = 20;
    localparam int PAGE_W  = 14;
    localparam int TIME_W  = 32;
    localparam int FAULT_W = 16;
    localparam int FIDX_W  = 3;

    localparam int IDX_W  = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int FILL_W = $clog2(FRAME_COUNT + 1);

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int RECIP_W    = ADDR_W + PAGE_SHIFT + 1;
    localparam int PROD_W     = ADDR_W + RECIP_W;
    localparam int QUOT_LSB   = ADDR_W + PAGE_SHIFT;
    localparam longint unsigned RECIP =
        ((64'd1 << (ADDR_W + PAGE_SHIFT)) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              last_in_run;
    } access_t;

    typedef struct packed {
        logic               hit;
        logic [FIDX_W-1:0]  frame_index;
        logic               replaced;
        logic [PAGE_W-1:0]  evicted_page;
        logic [FAULT_W-1:0] fault_count;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

endpackage
`default_nettype wire

// ===== rtl/page_frame_replacement.sv =====
// Top level: page frame replacement engine with FIFO and LRU victim selection.
//
// Usage:
//   access channel (access_valid / access_stall / access_data) carries one
//   address and a last_in_run flag per transaction. result channel
//   (result_valid / result_stall / result_data) returns one result per access.
//   cfg channel (cfg_valid / cfg_ready / cfg_data) writes the policy bit,
//   0 = FIFO, 1 = LRU; write it only while the engine is idle.
// Sequence:
//   After an access is accepted, the divide state computes the page number by
//   reciprocal multiply; the scan state then walks the F filled frames (at
//   most FRAME_COUNT) through one shared compare unit, and a hit ends the
//   search early; with no filled frame the scan is skipped. The update state
//   writes the table and the result register, and the engine then returns to
//   idle, so a new access is accepted only after the last one is committed.
// Reset: table empty, time and fault count zero, policy FIFO; no clearing pass.
// Stall: the result register holds a finished result while the next access is
//   accepted and searched; the update waits only if that result is still held.
`default_nettype none
module page_frame_replacement (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 access_valid,
    output logic                access_stall,
    input  prf_pkg::access_t    access_data,
    output logic                result_valid,
    input  wire                 result_stall,
    output prf_pkg::result_t    result_data,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire                 cfg_data
);
    import prf_pkg::*;

    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

    state_t state_reg, state_next;

    logic                policy_reg;
    logic [FILL_W-1:0]   filled_reg;
    logic [TIME_W-1:0]   time_reg;
    logic [FAULT_W-1:0]  faults_reg;
    logic                result_valid_reg;
    result_t             result_reg;

    logic [ADDR_W-1:0]   address_reg;
    logic                last_reg;
    logic [PAGE_W-1:0]   page_reg;
    logic [IDX_W-1:0]    scan_reg;
    logic                hit_reg;
    logic [IDX_W-1:0]    hit_idx_reg;
    logic [IDX_W-1:0]    best_idx_reg;
    logic [TIME_W-1:0]   best_time_reg;
    logic [PAGE_W-1:0]   best_page_reg;

    logic [PAGE_W-1:0]   frame_page_mem [FRAME_COUNT];
    logic [TIME_W-1:0]   frame_load_mem [FRAME_COUNT];
    logic [TIME_W-1:0]   frame_use_mem  [FRAME_COUNT];

    logic [PROD_W-1:0]   product;
    logic [TIME_W-1:0]   cur_time;
    logic                page_match;
    logic                better;
    logic                scan_last;
    logic                table_full;
    logic                commit;
    logic                wr_fill;
    logic [IDX_W-1:0]    wr_idx;
    logic [FAULT_W-1:0]  faults_next;
    logic [31:0]         wr_idx_wide;
    result_t             result_next;

    assign product    = PROD_W'(address_reg) * PROD_W'(RECIP_C);
    assign cur_time   = policy_reg ? frame_use_mem[scan_reg] : frame_load_mem[scan_reg];
    assign page_match = (frame_page_mem[scan_reg] == page_reg);
    assign better     = (scan_reg == '0) || (cur_time < best_time_reg);
    assign scan_last  = (FILL_W'(FILL_W'(scan_reg) + FILL_W'(1)) == filled_reg);
    assign table_full = (filled_reg == FILL_W'(FRAME_COUNT));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (access_valid)
                    state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                state_next = (filled_reg == '0) ? ST_UPDATE : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (page_match || scan_last)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (commit)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        access_stall = (state_reg != ST_IDLE);
        commit       = (state_reg == ST_UPDATE) && (!result_valid_reg || !result_stall);
        cfg_ready    = 1'b1;
        result_valid = result_valid_reg;
        result_data  = result_reg;
    end

    always_comb
    begin
        wr_fill     = !hit_reg;
        faults_next = faults_reg;
        if (hit_reg)
            wr_idx = hit_idx_reg;
        else if (!table_full)
            wr_idx = filled_reg[IDX_W-1:0];
        else
            wr_idx = best_idx_reg;
        if (!hit_reg && table_full && (faults_reg != '1))
            faults_next = faults_reg + FAULT_W'(1);
        wr_idx_wide              = 32'(wr_idx);
        result_next.hit          = hit_reg;
        result_next.frame_index  = wr_idx_wide[FIDX_W-1:0];
        result_next.replaced     = !hit_reg && table_full;
        result_next.evicted_page = (!hit_reg && table_full) ? best_page_reg : '0;
        result_next.fault_count  = faults_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            policy_reg       <= 1'b0;
            filled_reg       <= '0;
            time_reg         <= '0;
            faults_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                policy_reg <= cfg_data;
            if (commit)
            begin
                result_valid_reg <= 1'b1;
                if (last_reg)
                begin
                    filled_reg <= '0;
                    time_reg   <= '0;
                    faults_reg <= '0;
                end
                else
                begin
                    time_reg   <= time_reg + TIME_W'(1);
                    faults_reg <= faults_next;
                    if (!hit_reg && !table_full)
                        filled_reg <= filled_reg + FILL_W'(1);
                end
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && access_valid)
        begin
            address_reg <= access_data.address;
            last_reg    <= access_data.last_in_run;
        end
        if (state_reg == ST_DIVIDE)
        begin
            page_reg <= product[QUOT_LSB +: PAGE_W];
            scan_reg <= '0;
            hit_reg  <= 1'b0;
        end
        if (state_reg == ST_SCAN)
        begin
            if (page_match)
            begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= scan_reg;
            end
            if (better)
            begin
                best_idx_reg  <= scan_reg;
                best_time_reg <= cur_time;
                best_page_reg <= frame_page_mem[scan_reg];
            end
            scan_reg <= scan_reg + IDX_W'(1);
        end
        if (commit)
        begin
            result_reg            <= result_next;
            frame_use_mem[wr_idx] <= time_reg;
            if (wr_fill)
            begin
                frame_page_mem[wr_idx] <= page_reg;
                frame_load_mem[wr_idx] <= time_reg;
            end
        end
    end

endmodule
`default_nettype wire
